@@ rtl/core/mfmd_pkg.sv @@
// ----------------------------------------------------------------------------
// Motor feedback decoder package
// Widths, reset values and register indexes shared by the decoder files.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mfmd_pkg;

  localparam int unsigned NUM_MOTORS_DEFAULT = 4;

  localparam int unsigned ID_W     = 11;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned ANGLE_W  = 16;
  localparam int unsigned WORD_W   = 16;
  localparam int unsigned SLOT_W   = 2;
  localparam int unsigned COUNT_W  = 32;
  localparam int unsigned TOTAL_W  = 48;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [ID_W-1:0]    RESET_ID_BASE        = 11'd513;
  localparam logic [WORD_W-1:0]  RESET_WRAP_THRESHOLD = 16'd6000;
  localparam logic [WORD_W-1:0]  RESET_COUNTS_PER_REV = 16'd8192;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ID_BASE        = 2'd0,
    CFG_WRAP_THRESHOLD = 2'd1,
    CFG_COUNTS_PER_REV = 2'd2
  } cfg_idx_e;

endpackage

@@ rtl/core/mfmd_if.sv @@
// ----------------------------------------------------------------------------
// Motor feedback decoder channels
// Frame input, decoded result output and register write channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface mfmd_frame_if;
  import mfmd_pkg::*;

  logic              valid;
  logic              ready;
  logic [ID_W-1:0]   frame_id;
  logic [BYTE_W-1:0] byte0;
  logic [BYTE_W-1:0] byte1;
  logic [BYTE_W-1:0] byte2;
  logic [BYTE_W-1:0] byte3;
  logic [BYTE_W-1:0] byte4;
  logic [BYTE_W-1:0] byte5;
  logic [BYTE_W-1:0] byte6;

  modport source (
    output valid, frame_id, byte0, byte1, byte2, byte3, byte4, byte5, byte6,
    input  ready
  );
  modport sink (
    input  valid, frame_id, byte0, byte1, byte2, byte3, byte4, byte5, byte6,
    output ready
  );
endinterface

interface mfmd_result_if;
  import mfmd_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [SLOT_W-1:0]          motor_slot;
  logic [ANGLE_W-1:0]         angle;
  logic signed [WORD_W-1:0]   speed;
  logic signed [WORD_W-1:0]   current;
  logic [BYTE_W-1:0]          temperature;
  logic signed [COUNT_W-1:0]  turns;
  logic signed [TOTAL_W-1:0]  total_angle;
  logic [COUNT_W-1:0]         frames_seen;

  modport source (
    output valid, motor_slot, angle, speed, current, temperature, turns,
           total_angle, frames_seen,
    input  ready
  );
  modport sink (
    input  valid, motor_slot, angle, speed, current, temperature, turns,
           total_angle, frames_seen,
    output ready
  );
endinterface

interface mfmd_cfg_if;
  import mfmd_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/core/motor_feedback_multiturn_decoder_core.sv @@
// ----------------------------------------------------------------------------
// Motor feedback multiturn decoder
// Decodes motor feedback frames and tracks a turn count per motor.
//
// Each frame beat goes through three registers: the frame register, the
// state register where the per-motor angle, turn count and frame count are
// updated, and the result register after the counts-per-revolution multiply.
// A result passes the state register and the result register after its
// frame is taken, and one frame is taken in every cycle as long as results
// are taken; the per-motor update is one read-modify-write, so frames for
// the same motor may follow each other directly. Frames whose identifier is
// out of the configured range are dropped in the first stage and give no
// result. Users must write registers only while idle; nothing enforces it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module motor_feedback_multiturn_decoder_core #(
  parameter int unsigned NUM_MOTORS = mfmd_pkg::NUM_MOTORS_DEFAULT
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  mfmd_frame_if.sink    frame_i,
  mfmd_result_if.source result_o,
  mfmd_cfg_if.sink      cfg_i
);
  import mfmd_pkg::*;

  localparam int unsigned SlotIdxW = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;

  // Configuration registers.
  logic [ID_W-1:0]   id_base_q;
  logic [WORD_W-1:0] wrap_thr_q;
  logic [WORD_W-1:0] cpr_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      id_base_q  <= RESET_ID_BASE;
      wrap_thr_q <= RESET_WRAP_THRESHOLD;
      cpr_q      <= RESET_COUNTS_PER_REV;
    end else if (cfg_i.valid) begin
      unique case (cfg_idx_e'(cfg_i.index))
        CFG_ID_BASE:        id_base_q  <= cfg_i.data[ID_W-1:0];
        CFG_WRAP_THRESHOLD: wrap_thr_q <= cfg_i.data[WORD_W-1:0];
        CFG_COUNTS_PER_REV: cpr_q      <= cfg_i.data[WORD_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshake chain: each stage moves when its successor has room.
  logic s1_vld_q, s2_vld_q, out_vld_q;
  logic s1_rdy, s2_rdy, out_rdy;

  assign out_rdy       = !out_vld_q || result_o.ready;
  assign s2_rdy        = !s2_vld_q || out_rdy;
  assign s1_rdy        = !s1_vld_q || s2_rdy;
  assign frame_i.ready = s1_rdy;

  // Stage 1: frame register.
  logic [ID_W-1:0]   s1_id_q;
  logic [BYTE_W-1:0] s1_b0_q, s1_b1_q, s1_b2_q, s1_b3_q, s1_b4_q, s1_b5_q, s1_b6_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (s1_rdy) begin
      s1_vld_q <= frame_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_rdy && frame_i.valid) begin
      s1_id_q <= frame_i.frame_id;
      s1_b0_q <= frame_i.byte0;
      s1_b1_q <= frame_i.byte1;
      s1_b2_q <= frame_i.byte2;
      s1_b3_q <= frame_i.byte3;
      s1_b4_q <= frame_i.byte4;
      s1_b5_q <= frame_i.byte5;
      s1_b6_q <= frame_i.byte6;
    end
  end

  // Slot decode and per-motor state update.
  logic [ID_W-1:0]     id_off;
  logic                s1_hit;
  logic [SlotIdxW-1:0] s1_slot;
  logic [ANGLE_W-1:0]  s1_angle;
  logic signed [ANGLE_W:0] jump;
  logic signed [ANGLE_W:0] thr;
  logic [COUNT_W-1:0]  turns_d;
  logic [COUNT_W-1:0]  frames_d;
  logic                s1_fire;

  logic [ANGLE_W-1:0] prev_angle_q [NUM_MOTORS];
  logic [COUNT_W-1:0] turn_cnt_q   [NUM_MOTORS];
  logic [COUNT_W-1:0] frame_cnt_q  [NUM_MOTORS];

  assign id_off   = s1_id_q - id_base_q;
  assign s1_hit   = (s1_id_q >= id_base_q) && (id_off < ID_W'(NUM_MOTORS));
  assign s1_slot  = id_off[SlotIdxW-1:0];
  assign s1_angle = {s1_b0_q, s1_b1_q};
  assign jump     = $signed({1'b0, s1_angle}) - $signed({1'b0, prev_angle_q[s1_slot]});
  assign thr      = $signed({1'b0, wrap_thr_q});
  assign frames_d = frame_cnt_q[s1_slot] + COUNT_W'(1);
  assign s1_fire  = s1_vld_q && s2_rdy;

  // A large backward jump means the encoder crossed zero going forwards.
  always_comb begin
    priority if (jump < -thr) begin
      turns_d = turn_cnt_q[s1_slot] + COUNT_W'(1);
    end else if (jump > thr) begin
      turns_d = turn_cnt_q[s1_slot] - COUNT_W'(1);
    end else begin
      turns_d = turn_cnt_q[s1_slot];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_MOTORS; i++) begin
        prev_angle_q[i] <= '0;
        turn_cnt_q[i]   <= '0;
        frame_cnt_q[i]  <= '0;
      end
    end else if (s1_fire && s1_hit) begin
      prev_angle_q[s1_slot] <= s1_angle;
      turn_cnt_q[s1_slot]   <= turns_d;
      frame_cnt_q[s1_slot]  <= frames_d;
    end
  end

  // Stage 2: decoded fields and updated counts.
  logic [SLOT_W-1:0]  s2_slot_q;
  logic [ANGLE_W-1:0] s2_angle_q;
  logic [WORD_W-1:0]  s2_speed_q, s2_current_q;
  logic [BYTE_W-1:0]  s2_temp_q;
  logic [COUNT_W-1:0] s2_turns_q, s2_frames_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else if (s2_rdy) begin
      s2_vld_q <= s1_vld_q && s1_hit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && s1_hit) begin
      s2_slot_q    <= SLOT_W'(s1_slot);
      s2_angle_q   <= s1_angle;
      s2_speed_q   <= {s1_b2_q, s1_b3_q};
      s2_current_q <= {s1_b4_q, s1_b5_q};
      s2_temp_q    <= s1_b6_q;
      s2_turns_q   <= turns_d;
      s2_frames_q  <= frames_d;
    end
  end

  // Stage 3: total angle and result register.
  logic signed [WORD_W+COUNT_W:0] product;
  logic [TOTAL_W-1:0]             total_d;

  assign product = $signed({1'b0, cpr_q}) * $signed(s2_turns_q);
  assign total_d = product[TOTAL_W-1:0] + TOTAL_W'(s2_angle_q);

  logic [SLOT_W-1:0]  out_slot_q;
  logic [ANGLE_W-1:0] out_angle_q;
  logic [WORD_W-1:0]  out_speed_q, out_current_q;
  logic [BYTE_W-1:0]  out_temp_q;
  logic [COUNT_W-1:0] out_turns_q, out_frames_q;
  logic [TOTAL_W-1:0] out_total_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_rdy) begin
      out_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_rdy && s2_vld_q) begin
      out_slot_q    <= s2_slot_q;
      out_angle_q   <= s2_angle_q;
      out_speed_q   <= s2_speed_q;
      out_current_q <= s2_current_q;
      out_temp_q    <= s2_temp_q;
      out_turns_q   <= s2_turns_q;
      out_frames_q  <= s2_frames_q;
      out_total_q   <= total_d;
    end
  end

  assign result_o.valid       = out_vld_q;
  assign result_o.motor_slot  = out_slot_q;
  assign result_o.angle       = out_angle_q;
  assign result_o.speed       = $signed(out_speed_q);
  assign result_o.current     = $signed(out_current_q);
  assign result_o.temperature = out_temp_q;
  assign result_o.turns       = $signed(out_turns_q);
  assign result_o.total_angle = $signed(out_total_q);
  assign result_o.frames_seen = out_frames_q;

endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// Motor feedback multiturn decoder testbench
// Drives feedback frames and register writes into the decoder, predicts each
// decoded reading from a behavioural copy of the per-motor turn tracking and
// compares every result beat field by field, with random idling on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import mfmd_pkg::*;

  localparam int unsigned MOTORS      = NUM_MOTORS_DEFAULT;
  localparam int unsigned CYCLE_LIMIT = 500000;

  typedef struct packed {
    logic [ID_W-1:0]   frame_id;
    logic [BYTE_W-1:0] byte0;
    logic [BYTE_W-1:0] byte1;
    logic [BYTE_W-1:0] byte2;
    logic [BYTE_W-1:0] byte3;
    logic [BYTE_W-1:0] byte4;
    logic [BYTE_W-1:0] byte5;
    logic [BYTE_W-1:0] byte6;
  } can_frame_t;

  typedef struct {
    can_frame_t  frame;
    int unsigned gap;
  } queued_frame_t;

  typedef struct packed {
    logic [SLOT_W-1:0]  motor_slot;
    logic [ANGLE_W-1:0] angle;
    logic [WORD_W-1:0]  speed;
    logic [WORD_W-1:0]  current;
    logic [BYTE_W-1:0]  temperature;
    logic [COUNT_W-1:0] turns;
    logic [TOTAL_W-1:0] total_angle;
    logic [COUNT_W-1:0] frames_seen;
  } motor_reading_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always #5 clk_i = ~clk_i;

  mfmd_frame_if  frame_bus ();
  mfmd_result_if result_bus ();
  mfmd_cfg_if    cfg_bus ();

  motor_feedback_multiturn_decoder_core #(
    .NUM_MOTORS(MOTORS)
  ) DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .frame_i (frame_bus),
    .result_o(result_bus),
    .cfg_i   (cfg_bus)
  );

  // Local copies of everything the testbench drives, known from time zero.
  logic                  frame_valid  = 1'b0;
  can_frame_t            frame_drive  = '0;
  logic                  result_ready = 1'b0;
  logic                  cfg_valid    = 1'b0;
  cfg_idx_e              cfg_index    = CFG_ID_BASE;
  logic [CFG_DATA_W-1:0] cfg_data     = '0;

  assign frame_bus.valid    = frame_valid;
  assign frame_bus.frame_id = frame_drive.frame_id;
  assign frame_bus.byte0    = frame_drive.byte0;
  assign frame_bus.byte1    = frame_drive.byte1;
  assign frame_bus.byte2    = frame_drive.byte2;
  assign frame_bus.byte3    = frame_drive.byte3;
  assign frame_bus.byte4    = frame_drive.byte4;
  assign frame_bus.byte5    = frame_drive.byte5;
  assign frame_bus.byte6    = frame_drive.byte6;
  assign result_bus.ready   = result_ready;
  assign cfg_bus.valid      = cfg_valid;
  assign cfg_bus.index      = cfg_index;
  assign cfg_bus.data       = cfg_data;

  // Predicted register contents and per-motor tracking state.
  logic [ID_W-1:0]    base_id;
  logic [WORD_W-1:0]  cross_limit;
  logic [WORD_W-1:0]  counts_rev;
  logic [ANGLE_W-1:0] last_angle  [MOTORS];
  logic [COUNT_W-1:0] turn_tally  [MOTORS];
  logic [COUNT_W-1:0] frame_tally [MOTORS];

  queued_frame_t  pending_frames    [$];
  motor_reading_t feedback_expected [$];

  logic [ID_W-1:0]    traffic_base = RESET_ID_BASE;
  logic [ANGLE_W-1:0] spin_angle [MOTORS];
  bit                 sender_calm  = 1'b0;
  bit                 offering     = 1'b0;
  bit                 gap_armed    = 1'b0;
  int unsigned        gap_left     = 0;
  queued_frame_t      offer;
  int unsigned        fail_count   = 0;
  int unsigned        beats_taken  = 0;
  int unsigned        stall_left   = 0;
  int unsigned        hold_left    = 0;
  int unsigned        cycle_count  = 0;

  function automatic void track_motor_feedback(can_frame_t f);
    motor_reading_t     r;
    int                 offset;
    int                 jump;
    int                 limit;
    logic [ANGLE_W-1:0] ang;
    longint             total;
    offset = int'(f.frame_id) - int'(base_id);
    if (offset < 0 || offset >= int'(MOTORS)) return;
    ang   = {f.byte0, f.byte1};
    jump  = int'(ang) - int'(last_angle[offset]);
    limit = int'(cross_limit);
    // A large backward jump means the encoder rolled over forwards.
    if (jump < -limit) begin
      turn_tally[offset] += 32'd1;
    end else if (jump > limit) begin
      turn_tally[offset] -= 32'd1;
    end
    last_angle[offset]  = ang;
    frame_tally[offset] += 32'd1;
    total = longint'(ang) + longint'(counts_rev) * longint'(signed'(turn_tally[offset]));
    r.motor_slot  = SLOT_W'(offset);
    r.angle       = ang;
    r.speed       = {f.byte2, f.byte3};
    r.current     = {f.byte4, f.byte5};
    r.temperature = f.byte6;
    r.turns       = turn_tally[offset];
    r.total_angle = total[TOTAL_W-1:0];
    r.frames_seen = frame_tally[offset];
    feedback_expected.push_back(r);
  endfunction

  function automatic void check_field(string field, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      fail_count++;
      $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
    end
  endfunction

  function automatic void queue_frame(logic [ID_W-1:0] id, logic [15:0] ang,
                                      logic [15:0] spd, logic [15:0] cur, logic [7:0] tmp);
    queued_frame_t item;
    item.frame = '{frame_id: id, byte0: ang[15:8], byte1: ang[7:0], byte2: spd[15:8],
                   byte3: spd[7:0], byte4: cur[15:8], byte5: cur[7:0], byte6: tmp};
    item.gap   = sender_calm ? 0 : $urandom_range(0, 14);
    pending_frames.push_back(item);
  endfunction

  // Mostly frames for the configured motors whose angles follow a rotation, so
  // that the turn count really moves; the rest are jumps and foreign frames.
  function automatic void queue_random_traffic(int unsigned wanted);
    int unsigned        issued;
    int unsigned        pick;
    int unsigned        slot;
    int                 id;
    int                 step;
    logic [ANGLE_W-1:0] ang;
    issued = 0;
    while (issued < wanted) begin
      if (issued % 60 == 0) sender_calm = ($urandom_range(0, 2) == 0);
      issued++;
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
        case ($urandom_range(0, 2))
          0:       id = $urandom_range(0, 2047);
          1:       id = int'(traffic_base) - 1;
          default: id = int'(traffic_base) + int'(MOTORS);
        endcase
        queue_frame(ID_W'(id), 16'($urandom), 16'($urandom), 16'($urandom), 8'($urandom));
      end else begin
        slot = $urandom_range(0, MOTORS - 1);
        id   = int'(traffic_base) + int'(slot);
        if (pick < 27) begin
          ang = 16'($urandom);
        end else begin
          step = int'($urandom_range(0, 24000)) - 12000;
          ang  = spin_angle[slot] + 16'(step);
        end
        spin_angle[slot] = ang;
        queue_frame(ID_W'(id), ang, 16'($urandom), 16'($urandom), 8'($urandom));
      end
    end
    sender_calm = 1'b0;
  endfunction

  task automatic write_register(cfg_idx_e idx, logic [CFG_DATA_W-1:0] value);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk_i); while (!cfg_bus.ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic configure(logic [15:0] base_data, logic [15:0] limit, logic [15:0] counts);
    write_register(CFG_ID_BASE, base_data);
    write_register(CFG_WRAP_THRESHOLD, limit);
    write_register(CFG_COUNTS_PER_REV, counts);
    traffic_base = base_data[ID_W-1:0];
  endtask

  // A dropped frame leaves no expectation, so a few spare cycles follow the
  // last result before the block counts as idle.
  task automatic drain_and_settle();
    while (pending_frames.size() != 0 || offering || feedback_expected.size() != 0)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // Register shadow and tracking state.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      base_id     = RESET_ID_BASE;
      cross_limit = RESET_WRAP_THRESHOLD;
      counts_rev  = RESET_COUNTS_PER_REV;
      foreach (last_angle[m]) begin
        last_angle[m]  = '0;
        turn_tally[m]  = '0;
        frame_tally[m] = '0;
      end
    end else if (cfg_valid && cfg_bus.ready) begin
      case (cfg_index)
        CFG_ID_BASE:        base_id     = cfg_data[ID_W-1:0];
        CFG_WRAP_THRESHOLD: cross_limit = cfg_data;
        CFG_COUNTS_PER_REV: counts_rev  = cfg_data;
        default: ;
      endcase
    end
  end

  // Frame driver.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      frame_valid <= 1'b0;
      offering    = 1'b0;
      gap_armed   = 1'b0;
    end else begin
      if (frame_valid && frame_bus.ready) begin
        track_motor_feedback(offer.frame);
        offering = 1'b0;
      end
      if (!offering && pending_frames.size() != 0) begin
        if (!gap_armed) begin
          gap_left  = pending_frames[0].gap;
          gap_armed = 1'b1;
        end
        if (gap_left == 0) begin
          offer       = pending_frames.pop_front();
          offering    = 1'b1;
          gap_armed   = 1'b0;
          frame_drive <= offer.frame;
        end else begin
          gap_left--;
        end
      end
      frame_valid <= offering;
    end
  end

  // Result monitor with receiver back-pressure.
  always @(posedge clk_i) begin
    motor_reading_t seen;
    motor_reading_t want;
    if (!rst_ni) begin
      result_ready <= 1'b0;
    end else begin
      if (result_bus.valid && result_ready) begin
        seen.motor_slot  = result_bus.motor_slot;
        seen.angle       = result_bus.angle;
        seen.speed       = result_bus.speed;
        seen.current     = result_bus.current;
        seen.temperature = result_bus.temperature;
        seen.turns       = result_bus.turns;
        seen.total_angle = result_bus.total_angle;
        seen.frames_seen = result_bus.frames_seen;
        if (feedback_expected.size() == 0) begin
          fail_count++;
          $error("result beat with no frame waiting for it");
        end else begin
          want = feedback_expected.pop_front();
          check_field("motor_slot", 64'(want.motor_slot), 64'(seen.motor_slot));
          check_field("angle", 64'(want.angle), 64'(seen.angle));
          check_field("speed", 64'(want.speed), 64'(seen.speed));
          check_field("current", 64'(want.current), 64'(seen.current));
          check_field("temperature", 64'(want.temperature), 64'(seen.temperature));
          check_field("turns", 64'(want.turns), 64'(seen.turns));
          check_field("total_angle", 64'(want.total_angle), 64'(seen.total_angle));
          check_field("frames_seen", 64'(want.frames_seen), 64'(seen.frames_seen));
        end
        beats_taken++;
        stall_left = ((beats_taken / 100) % 3 == 1) ? 0 : $urandom_range(0, 14);
        // Long hold-offs let the sender fill the pipeline and stall its input.
        if (beats_taken == 150 || beats_taken == 800) hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        result_ready <= 1'b0;
      end else begin
        result_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    int unsigned round;
    foreach (spin_angle[m]) spin_angle[m] = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed frames under the reset configuration, back to back.
    sender_calm = 1'b1;
    queue_frame(11'd513, 16'h0000, 16'h0000, 16'h0000, 8'h00);
    queue_frame(11'd514, 16'hFFFF, 16'h7FFF, 16'h7FFF, 8'hFF);
    queue_frame(11'd515, 16'd6000, 16'h8000, 16'h8000, 8'h80);
    queue_frame(11'd516, 16'd6001, 16'hFFFF, 16'h0001, 8'h01);
    queue_frame(11'd515, 16'd0, 16'h0001, 16'hFFFF, 8'h7F);
    queue_frame(11'd515, 16'hFFFF, 16'h5AA5, 16'hA55A, 8'h55);
    queue_frame(11'd515, 16'd59534, 16'hA55A, 16'h5AA5, 8'hAA);
    queue_frame(11'd512, 16'h1234, 16'h1234, 16'h1234, 8'h12);
    queue_frame(11'd517, 16'h4321, 16'h4321, 16'h4321, 8'h43);
    queue_frame(11'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF);
    queue_frame(11'd2047, 16'h0000, 16'h0000, 16'h0000, 8'h00);
    queue_frame(11'd513, 16'd8000, 16'h0100, 16'hFF00, 8'h10);
    queue_frame(11'd513, 16'd100, 16'h0200, 16'hFE00, 8'h20);
    queue_frame(11'd513, 16'd8100, 16'h0300, 16'hFD00, 8'h30);
    queue_frame(11'd513, 16'd16000, 16'h0400, 16'hFC00, 8'h40);
    queue_frame(11'd513, 16'd24000, 16'h0500, 16'hFB00, 8'h50);
    queue_frame(11'd514, 16'h0000, 16'h8000, 16'h7FFF, 8'hFE);
    queue_frame(11'd516, 16'hFFFF, 16'h7FFF, 16'h8000, 8'h01);
    sender_calm = 1'b0;
    queue_random_traffic(350);
    drain_and_settle();

    // Window at the top of the identifier space; upper data bits are ignored.
    configure({5'b10101, 11'd2046}, 16'd0, 16'hFFFF);
    queue_random_traffic(250);
    drain_and_settle();

    configure(16'd0, 16'hFFFF, 16'd1);
    queue_random_traffic(250);
    drain_and_settle();

    // Zero counts per revolution leaves the total equal to the angle.
    configure({5'b01010, 11'd2047}, 16'($urandom_range(0, 20000)), 16'd0);
    queue_random_traffic(250);
    drain_and_settle();

    for (round = 0; round < 4; round++) begin
      configure(16'($urandom), 16'($urandom_range(0, 20000)), 16'($urandom));
      queue_random_traffic(200);
      drain_and_settle();
    end

    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/mfmd_pkg.sv
rtl/core/mfmd_if.sv
rtl/core/motor_feedback_multiturn_decoder_core.sv
tb/tb_top.sv
